FILE: rtl/skyra_pkg.sv
// Shared types, codes and default sizes for the skyline rectangle allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package skyra_pkg;

    // Default sheet geometry.
    localparam int SHEET_WIDTH_DEF  = 256;
    localparam int SHEET_HEIGHT_DEF = 256;

    // Fixed field widths of the request and response.
    localparam int ACT_W  = 2;
    localparam int REQW_W = 8;
    localparam int REQH_W = 9;
    localparam int POS_W  = 8;
    localparam int TOP_W  = 9;
    localparam int OP_W   = 2;

    // Request action codes.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RETRY = 2'd2;

    // Datapath operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_PASS1 = 2'd1;
    localparam logic [OP_W-1:0] OP_PASS2 = 2'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [REQW_W-1:0] req_width;
        logic [REQH_W-1:0] req_height;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             restarted;
        logic [TOP_W-1:0] top_height;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            init;
        logic            step;
        logic            load;
        logic            restart;
        logic            emit;
        logic            emit_ok;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic fits;
        logic retry_ok;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/skyline_rectangle_allocator_core.sv
// Top level of the skyline rectangle allocator.
// Depends on skyra_pkg, skyra_ctrl, skyra_dp and skyra_ram.

// Packs rectangles into a SHEET_WIDTH by SHEET_HEIGHT sheet kept as a skyline
// of column heights in a RAM. A request clears the sheet, allocates, or
// allocates with one clear-and-retry on failure; each request gives exactly
// one response. An allocation makes two streaming passes over the skyline
// RAM, one column per cycle (left to right storing block prefix maxima, then
// right to left combining them with block suffix maxima to get every window
// maximum), then writes the chosen columns; a retry that restarts adds a
// clear of the sheet and a second search. After reset the block sweeps the
// skyline to zero with req_ready low. One request is worked at a time; a
// finished response waits in an output register, and the next request is
// taken while it waits.
module skyline_rectangle_allocator_core #(
    parameter int SHEET_WIDTH  = skyra_pkg::SHEET_WIDTH_DEF,
    parameter int SHEET_HEIGHT = skyra_pkg::SHEET_HEIGHT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  skyra_pkg::req_t req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output skyra_pkg::rsp_t rsp_data
);
    import skyra_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    skyra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_action(req_data.action),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Skyline storage, window search and response register.
    skyra_dp #(
        .SHEET_WIDTH (SHEET_WIDTH),
        .SHEET_HEIGHT(SHEET_HEIGHT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .rsp_ready(rsp_ready),
        .rsp_valid(rsp_valid),
        .rsp_data (rsp_data),
        .cmd      (cmd),
        .sts      (sts)
    );

`ifndef NO_ASSERTIONS
    // A response is loaded only when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
        else $error("response loaded over a pending response");

    // Only one request is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in work");

    // Columns are written back only for a placement that fits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.init && (cmd.op == OP_WRITE)) |-> sts.fits)
        else $error("write-back started without a fitting window");

    // A restarted response always reports a placement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.restarted) |-> rsp_data.ok)
        else $error("restarted set on a failed response");
`endif

endmodule

FILE: rtl/skyra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the skyline and the block prefix-maximum storage.
module skyra_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/skyra_ctrl.sv
// Sequencing state machine of the skyline rectangle allocator.
// Depends on skyra_pkg; drives the datapath through cmd_t and reads sts_t.
module skyra_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic [skyra_pkg::ACT_W-1:0]    req_action,
    output logic                           req_ready,
    output skyra_pkg::cmd_t                cmd,
    input  skyra_pkg::sts_t                sts
);
    import skyra_pkg::*;

    localparam logic [3:0] ST_BOOT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_CLR  = 4'd2;
    localparam logic [3:0] ST_P1   = 4'd3;
    localparam logic [3:0] ST_P1D  = 4'd4;
    localparam logic [3:0] ST_P2   = 4'd5;
    localparam logic [3:0] ST_P2D  = 4'd6;
    localparam logic [3:0] ST_DEC  = 4'd7;
    localparam logic [3:0] ST_WB   = 4'd8;
    localparam logic [3:0] ST_RCLR = 4'd9;
    localparam logic [3:0] ST_EMIT = 4'd10;
    localparam logic [3:0] ST_RP1  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ok_reg;
    logic       ok_next;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        ok_next     = ok_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.emit_ok = ok_reg;
        unique case (state_reg)
            ST_BOOT:
            begin
                cmd.op   = OP_CLEAR;
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (req_action)
                        ACT_CLEAR:
                        begin
                            cmd.op     = OP_CLEAR;
                            cmd.init   = 1'b1;
                            state_next = ST_CLR;
                        end
                        ACT_ALLOC, ACT_RETRY:
                        begin
                            cmd.op     = OP_PASS1;
                            cmd.init   = 1'b1;
                            state_next = ST_P1;
                        end
                        default:
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CLR:
            begin
                cmd.op   = OP_CLEAR;
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    ok_next    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_P1:
            begin
                cmd.op   = OP_PASS1;
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_P1D;
                end
            end
            ST_P1D:
            begin
                // The last prefix value is written while pass two is set up.
                cmd.op     = OP_PASS2;
                cmd.init   = 1'b1;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                cmd.op   = OP_PASS2;
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_P2D;
                end
            end
            ST_P2D:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                priority if (sts.fits)
                begin
                    cmd.op     = OP_WRITE;
                    cmd.init   = 1'b1;
                    state_next = ST_WB;
                end
                else if (sts.retry_ok)
                begin
                    cmd.op      = OP_CLEAR;
                    cmd.init    = 1'b1;
                    cmd.restart = 1'b1;
                    state_next  = ST_RCLR;
                end
                else
                begin
                    ok_next    = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_WB:
            begin
                cmd.op   = OP_WRITE;
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    ok_next    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_RCLR:
            begin
                cmd.op   = OP_CLEAR;
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_RP1;
                end
            end
            ST_RP1:
            begin
                // The sheet is clear; set up the second search.
                cmd.op     = OP_PASS1;
                cmd.init   = 1'b1;
                state_next = ST_P1;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers; reset starts the skyline clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

endmodule

FILE: rtl/skyra_dp.sv
// Datapath of the skyline rectangle allocator: skyline and prefix RAMs,
// scan counters, window search and the response register. Uses skyra_pkg, skyra_ram.
module skyra_dp #(
    parameter int SHEET_WIDTH  = skyra_pkg::SHEET_WIDTH_DEF,
    parameter int SHEET_HEIGHT = skyra_pkg::SHEET_HEIGHT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  skyra_pkg::req_t req_data,
    input  logic            rsp_ready,
    output logic            rsp_valid,
    output skyra_pkg::rsp_t rsp_data,
    input  skyra_pkg::cmd_t cmd,
    output skyra_pkg::sts_t sts
);
    import skyra_pkg::*;

    localparam int XW   = $clog2(SHEET_WIDTH);
    localparam int HW   = $clog2(SHEET_HEIGHT + 1);
    localparam int EW   = ((XW > REQW_W) ? XW : REQW_W) + 1;
    localparam int SUMW = ((HW > REQH_W) ? HW : REQH_W) + 1;

    localparam logic [XW-1:0]   LAST_COL = XW'(SHEET_WIDTH - 2);
    localparam logic [XW-1:0]   K_MAX    = XW'(SHEET_WIDTH - 1);
    localparam logic [HW-1:0]   SH_VAL   = HW'(SHEET_HEIGHT);
    localparam logic [EW-1:0]   SW_EXT   = EW'(SHEET_WIDTH);
    localparam logic [SUMW-1:0] SH_EXT   = SUMW'(SHEET_HEIGHT);

    // Request and scan registers.
    logic [ACT_W-1:0]  act_reg,       act_next;
    logic [REQW_W-1:0] w_reg,         w_next;
    logic [REQH_W-1:0] h_reg,         h_next;
    logic              restarted_reg, restarted_next;
    logic [XW-1:0]     k_reg,         k_next;
    logic [REQW_W-1:0] c_reg,         c_next;
    logic              st_vld_reg,    st_vld_next;
    logic [OP_W-1:0]   st_op_reg,     st_op_next;
    logic [XW-1:0]     st_k_reg,      st_k_next;
    logic              st_brk_reg,    st_brk_next;
    logic [HW-1:0]     run_reg,       run_next;
    logic [HW-1:0]     best_reg,      best_next;
    logic [XW-1:0]     bx_reg,        bx_next;
    logic              found_reg,     found_next;
    logic [HW-1:0]     highest_reg,   highest_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg,       rsp_next;

    logic [REQW_W-1:0] w_m1;
    logic [REQW_W-1:0] c_inc;
    logic [REQW_W-1:0] c_dec;
    logic              brk;
    logic [HW-1:0]     col_rd;
    logic [HW-1:0]     pre_rd;
    logic [HW-1:0]     run_val;
    logic [HW-1:0]     win_max;
    logic [EW-1:0]     st_end_ext;
    logic              cand;
    logic [EW-1:0]     pre_raddr_ext;
    logic [XW-1:0]     pre_raddr;
    logic [SUMW-1:0]   sum_ext;
    logic [HW-1:0]     top_val;
    logic              w_ok;
    logic              fits;
    logic [EW-1:0]     wb_end_ext;
    logic              col_we;
    logic [HW-1:0]     col_wdata;
    logic              pre_we;
    logic              placed;
    logic [EW-1:0]     bx_ext;
    logic [SUMW-1:0]   best_ext;
    logic [SUMW-1:0]   highest_ext;

    // Skyline column heights.
    skyra_ram #(
        .WIDTH(HW),
        .DEPTH(SHEET_WIDTH)
    ) u_col_ram (
        .clk  (clk),
        .we   (col_we),
        .waddr(k_reg),
        .wdata(col_wdata),
        .raddr(k_reg),
        .rdata(col_rd)
    );

    // Running maximum from each block start, written in pass one.
    skyra_ram #(
        .WIDTH(HW),
        .DEPTH(SHEET_WIDTH)
    ) u_pre_ram (
        .clk  (clk),
        .we   (pre_we),
        .waddr(st_k_reg),
        .wdata(run_val),
        .raddr(pre_raddr),
        .rdata(pre_rd)
    );

    // Block phase counter: blocks of req_width columns anchored at column zero.
    assign w_m1  = w_reg - REQW_W'(1);
    assign c_inc = (c_reg == w_m1) ? '0 : c_reg + REQW_W'(1);
    assign c_dec = (c_reg == '0) ? w_m1 : c_reg - REQW_W'(1);
    assign brk   = (cmd.op == OP_PASS1) ? (c_reg == '0)
                                        : ((c_reg == w_m1) || (k_reg == LAST_COL));

    // Read stage: running block maximum and window maximum.
    // A window is the block suffix at its left edge joined with the block prefix at its right.
    assign run_val    = st_brk_reg ? col_rd : ((col_rd > run_reg) ? col_rd : run_reg);
    assign win_max    = (run_val > pre_rd) ? run_val : pre_rd;
    assign st_end_ext = EW'(st_k_reg) + EW'(w_reg);
    assign cand       = st_vld_reg && (st_op_reg == OP_PASS2) && (st_end_ext < SW_EXT)
                        && (win_max < SH_VAL) && (win_max <= best_reg);

    assign pre_raddr_ext = EW'(k_reg) + EW'(w_m1);
    assign pre_raddr     = pre_raddr_ext[XW-1:0];

    // Placement test and new column height.
    assign sum_ext    = SUMW'(best_reg) + SUMW'(h_reg);
    assign top_val    = sum_ext[HW-1:0];
    assign w_ok       = (w_reg != '0) && (h_reg != '0) && (EW'(w_reg) < SW_EXT);
    assign fits       = w_ok && found_reg && (sum_ext <= SH_EXT);
    assign wb_end_ext = EW'(bx_reg) + EW'(w_m1);

    assign col_we    = cmd.step && ((cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE));
    assign col_wdata = (cmd.op == OP_WRITE) ? top_val : '0;
    assign pre_we    = st_vld_reg && (st_op_reg == OP_PASS1);

    // Status toward the controller.
    always_comb
    begin
        sts = '0;
        unique case (cmd.op)
            OP_CLEAR: sts.last = (k_reg == K_MAX);
            OP_PASS1: sts.last = (k_reg == LAST_COL);
            OP_PASS2: sts.last = (k_reg == '0);
            OP_WRITE: sts.last = (EW'(k_reg) == wb_end_ext);
            default:  sts.last = 1'b0;
        endcase
        sts.fits     = fits;
        sts.retry_ok = (act_reg == ACT_RETRY) && !restarted_reg;
        sts.out_free = !rsp_valid_reg || rsp_ready;
    end

    // Response fields are widened first so any sheet size truncates cleanly.
    assign placed      = cmd.emit_ok && (act_reg != ACT_CLEAR);
    assign bx_ext      = EW'(bx_reg);
    assign best_ext    = SUMW'(best_reg);
    assign highest_ext = SUMW'(highest_reg);

    // Next-state logic of all datapath registers.
    always_comb
    begin
        act_next       = act_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        restarted_next = restarted_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        st_vld_next    = cmd.step && ((cmd.op == OP_PASS1) || (cmd.op == OP_PASS2));
        st_op_next     = cmd.op;
        st_k_next      = k_reg;
        st_brk_next    = brk;
        run_next       = st_vld_reg ? run_val : run_reg;
        best_next      = best_reg;
        bx_next        = bx_reg;
        found_next     = found_reg;
        highest_next   = highest_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        // Latch a new request.
        if (cmd.load)
        begin
            act_next       = req_data.action;
            w_next         = req_data.req_width;
            h_next         = req_data.req_height;
            restarted_next = 1'b0;
        end
        if (cmd.restart)
        begin
            restarted_next = 1'b1;
        end

        // Scan counters.
        if (cmd.init)
        begin
            unique case (cmd.op)
                OP_CLEAR:
                begin
                    k_next       = '0;
                    highest_next = '0;
                end
                OP_PASS1:
                begin
                    k_next = '0;
                    c_next = '0;
                end
                OP_PASS2:
                begin
                    k_next     = LAST_COL;
                    c_next     = c_dec;
                    best_next  = SH_VAL;
                    found_next = 1'b0;
                end
                OP_WRITE:
                begin
                    k_next = bx_reg;
                    if (top_val > highest_reg)
                    begin
                        highest_next = top_val;
                    end
                end
                default:
                begin
                    k_next = k_reg;
                end
            endcase
        end
        else if (cmd.step)
        begin
            unique case (cmd.op)
                OP_PASS1:
                begin
                    k_next = k_reg + XW'(1);
                    c_next = c_inc;
                end
                OP_PASS2:
                begin
                    k_next = k_reg - XW'(1);
                    c_next = c_dec;
                end
                default:
                begin
                    k_next = k_reg + XW'(1);
                end
            endcase
        end

        // Keep the lowest window; the scan runs right to left, so ties go left.
        if (cand)
        begin
            best_next  = win_max;
            bx_next    = st_k_reg;
            found_next = 1'b1;
        end

        // Response register.
        if (cmd.emit)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.ok          = cmd.emit_ok;
            rsp_next.pos_x       = placed ? bx_ext[POS_W-1:0] : '0;
            rsp_next.pos_y       = placed ? best_ext[POS_W-1:0] : '0;
            rsp_next.restarted   = cmd.emit_ok && restarted_reg;
            rsp_next.top_height  = highest_ext[TOP_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restarted_reg <= 1'b0;
            k_reg         <= '0;
            c_reg         <= '0;
            st_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            highest_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            restarted_reg <= restarted_next;
            k_reg         <= k_next;
            c_reg         <= c_next;
            st_vld_reg    <= st_vld_next;
            found_reg     <= found_next;
            highest_reg   <= highest_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        st_op_reg  <= st_op_next;
        st_k_reg   <= st_k_next;
        st_brk_reg <= st_brk_next;
        run_reg    <= run_next;
        best_reg   <= best_next;
        bx_reg     <= bx_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
